// ===== design/dkct_pkg.sv =====
// Package with the beat types, widths and codes of the distinct-key counting table.
package dkct_pkg;

    localparam int ENTRIES_DEFAULT = 32;
    localparam int KEY_W           = 16;
    localparam int COUNT_W         = 16;
    localparam int SLOT_W          = 5;
    localparam int DISTINCT_W      = 6;
    localparam int STATUS_W        = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [STATUS_W-1:0] STATUS_HIT  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NEW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] device_id;
        logic             start_of_batch;
    } in_beat_t;

    typedef struct packed {
        logic [SLOT_W-1:0]     slot;
        logic [COUNT_W-1:0]    slot_count;
        logic [COUNT_W-1:0]    total_count;
        logic [DISTINCT_W-1:0] distinct_count;
        logic [STATUS_W-1:0]   status;
    } out_beat_t;

    // One entry of the table memory: its count above its key.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [KEY_W-1:0]   key;
    } entry_t;

    // Increment that stops at the largest count.
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

endpackage

// ===== design/distinct_key_counting_table.sv =====
// Top level of the distinct-key counting table: search sequencer, counters and result register.
//
// The block counts how often each 16-bit device identifier occurs in a batch. An input beat
// whose start_of_batch bit is set empties the table before its identifier is handled. The
// identifier is compared with the stored keys in slot order, one key per clock cycle, read
// from a single synchronous RAM that holds the key and the count of each slot. A hit raises
// that slot's count and the batch total; a miss appends the key with count one if a slot is
// free, and otherwise the beat is dropped with the full status and is not counted. Counts
// stop at 65535. A beat passes through an accept step, a search over the stored keys,
// and an update step that writes the RAM and loads the result once the output register
// is free; a hit ends the search early, and a beat that finds the table empty skips the
// search. The block takes one beat at a time. The result sits in an output register, and
// the next input beat is accepted while that result still waits to be taken. The table
// memory needs no clearing after reset, because only slots below the fill count are ever
// compared.
module distinct_key_counting_table #(
    parameter int ENTRIES = dkct_pkg::ENTRIES_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dkct_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dkct_pkg::out_beat_t m_data
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int USED_W = $clog2(ENTRIES + 1);
    localparam int CMP_W  = USED_W + 1;
    localparam int ENT_W  = dkct_pkg::KEY_W + dkct_pkg::COUNT_W;

    // One-hot states of the search sequencer.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [dkct_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic                         hit_reg, hit_next;
    logic [dkct_pkg::COUNT_W-1:0] old_cnt_reg, old_cnt_next;
    logic [USED_W-1:0]            used_reg, used_next;
    logic [dkct_pkg::COUNT_W-1:0] total_reg, total_next;
    logic                         m_valid_reg, m_valid_next;
    dkct_pkg::out_beat_t          m_data_reg, m_data_next;

    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    dkct_pkg::entry_t             wr_entry;
    logic [IDX_W-1:0]             rd_addr;
    dkct_pkg::entry_t             rd_entry;

    logic                         out_free;
    logic                         last_cmp;
    logic [USED_W-1:0]            eff_used;

    dkct_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_table_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // The fill count that applies to the arriving beat: a new batch starts empty.
    assign eff_used = s_data.start_of_batch ? '0 : used_reg;

    // True when the slot now being compared is the last stored one.
    assign last_cmp = (CMP_W'(idx_reg) + CMP_W'(1)) == CMP_W'(used_reg);

    // The RAM read runs one slot ahead of the compare, so each cycle checks one key.
    always_comb begin
        rd_addr = '0;
        if (state_reg == ST_SEARCH && !last_cmp) begin
            rd_addr = idx_reg + IDX_W'(1);
        end
    end

    always_comb begin
        state_next   = state_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        old_cnt_next = old_cnt_reg;
        used_next    = used_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_entry     = '{count: dkct_pkg::COUNT_W'(1), key: key_reg};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next = s_data.device_id;
                    idx_next = '0;
                    hit_next = 1'b0;
                    if (s_data.start_of_batch) begin
                        used_next  = '0;
                        total_next = '0;
                    end
                    // With nothing stored, the search is skipped.
                    state_next = (eff_used == '0) ? ST_UPDATE : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (rd_entry.key == key_reg) begin
                    hit_next     = 1'b1;
                    old_cnt_next = rd_entry.count;
                    state_next   = ST_UPDATE;
                end else if (last_cmp) begin
                    state_next = ST_UPDATE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_UPDATE: begin
                // The table and the counters change only once the result can be loaded.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (hit_reg) begin
                        wr_en          = 1'b1;
                        wr_addr        = idx_reg;
                        wr_entry.count = dkct_pkg::sat_inc(old_cnt_reg);
                        total_next     = dkct_pkg::sat_inc(total_reg);
                        m_data_next = '{
                            slot:           dkct_pkg::SLOT_W'(idx_reg),
                            slot_count:     dkct_pkg::sat_inc(old_cnt_reg),
                            total_count:    dkct_pkg::sat_inc(total_reg),
                            distinct_count: dkct_pkg::DISTINCT_W'(used_reg),
                            status:         dkct_pkg::STATUS_HIT
                        };
                    end else if (used_reg != USED_W'(ENTRIES)) begin
                        // Append the key in the next free slot.
                        wr_en      = 1'b1;
                        wr_addr    = IDX_W'(used_reg);
                        used_next  = used_reg + USED_W'(1);
                        total_next = dkct_pkg::sat_inc(total_reg);
                        m_data_next = '{
                            slot:           dkct_pkg::SLOT_W'(used_reg),
                            slot_count:     dkct_pkg::COUNT_W'(1),
                            total_count:    dkct_pkg::sat_inc(total_reg),
                            distinct_count: dkct_pkg::DISTINCT_W'(used_reg + USED_W'(1)),
                            status:         dkct_pkg::STATUS_NEW
                        };
                    end else begin
                        // Table full: the beat is dropped and not counted.
                        m_data_next = '{
                            slot:           '0,
                            slot_count:     '0,
                            total_count:    total_reg,
                            distinct_count: dkct_pkg::DISTINCT_W'(used_reg),
                            status:         dkct_pkg::STATUS_FULL
                        };
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        idx_reg     <= idx_next;
        hit_reg     <= hit_next;
        old_cnt_reg <= old_cnt_next;
        m_data_reg  <= m_data_next;
    end

endmodule

// ===== design/dkct_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module dkct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== tb/tb_distinct_key_counting_table.sv =====
`timescale 1ns / 1ps
// Testbench of the distinct-key counting table, checked beat by beat against a local table model.
module tb_distinct_key_counting_table;

    // The table is built at its default size, and the local model uses the same size.
    localparam int TABLE_SLOTS      = dkct_pkg::ENTRIES_DEFAULT;
    // The watchdog counts cycles with no accepted beat on either channel. The longest
    // legitimate quiet stretch is the deliberate hold-off of the result channel,
    // followed by a full-length search. Random stalls and gaps are short by comparison.
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int IDLE_LIMIT       = 4000;
    // After the last result arrives, wait about two worst-case beat times.
    localparam int DRAIN_CYCLES     = 2 * (TABLE_SLOTS + 2);
    localparam int PRINT_LIMIT      = 30;
    localparam int RANDOM_PER_PHASE = 400;
    localparam int POOL_MAX         = TABLE_SLOTS + 16;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    dkct_pkg::in_beat_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    dkct_pkg::out_beat_t m_data;

    // Idling knobs, in percent per cycle. The receiver process counts down hold_left.
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_left       = 0;

    int error_count = 0;
    int idle_cycles = 0;

    // Local copy of the table contents, fill count and batch total.
    logic [dkct_pkg::KEY_W-1:0]   model_keys   [TABLE_SLOTS];
    logic [dkct_pkg::COUNT_W-1:0] model_counts [TABLE_SLOTS];
    int                           model_used  = 0;
    logic [dkct_pkg::COUNT_W-1:0] model_total = '0;

    // Result beats that the table still owes, oldest first.
    dkct_pkg::out_beat_t expected_tallies [$];
    dkct_pkg::out_beat_t oldest_tally;

    distinct_key_counting_table #(
        .ENTRIES(TABLE_SLOTS)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #5 aclk = ~aclk;

    // Counts stop at the largest value that the field holds.
    function automatic logic [dkct_pkg::COUNT_W-1:0] bump_count(
        input logic [dkct_pkg::COUNT_W-1:0] v);
        return (v == dkct_pkg::COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // Applies one input beat to the local table and returns the result beat it causes.
    // The search only looks at slots below the fill count, all of which were written
    // in the current batch, so stale contents from an older batch never matter.
    function automatic dkct_pkg::out_beat_t tally_key(input dkct_pkg::in_beat_t beat);
        dkct_pkg::out_beat_t r;
        int                  hit;
        r   = '0;
        hit = -1;
        if (beat.start_of_batch) begin
            model_used  = 0;
            model_total = '0;
        end
        for (int i = 0; i < model_used; i++) begin
            if (hit < 0 && model_keys[i] == beat.device_id) begin
                hit = i;
            end
        end
        if (hit >= 0) begin
            model_counts[hit] = bump_count(model_counts[hit]);
            model_total       = bump_count(model_total);
            r.slot            = dkct_pkg::SLOT_W'(hit);
            r.slot_count      = model_counts[hit];
            r.status          = dkct_pkg::STATUS_HIT;
        end else if (model_used < TABLE_SLOTS) begin
            model_keys[model_used]   = beat.device_id;
            model_counts[model_used] = dkct_pkg::COUNT_W'(1);
            model_total              = bump_count(model_total);
            r.slot                   = dkct_pkg::SLOT_W'(model_used);
            r.slot_count             = dkct_pkg::COUNT_W'(1);
            r.status                 = dkct_pkg::STATUS_NEW;
            model_used++;
        end else begin
            // The table is full: the beat is dropped, slot and count read zero, and
            // the total keeps its value because the beat is not counted.
            r.status = dkct_pkg::STATUS_FULL;
        end
        r.total_count    = model_total;
        r.distinct_count = dkct_pkg::DISTINCT_W'(model_used);
        return r;
    endfunction

    // Prints one line per failure, up to a limit, and counts every one.
    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("mismatch %0d at %0t ns: %s", error_count, $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            flag_error($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    // The result channel's ready: random stalls, or a solid hold-off while hold_left runs.
    // Only this process writes hold_left once it is nonzero, so the test may load it
    // whenever it is zero.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor and watchdog. All DUT and testbench signals change through nonblocking
    // assignments, so the values seen here are the ones the DUT saw at this edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            // Compare before predicting: a result taken at this edge always belongs to a
            // beat accepted at an earlier edge.
            if (m_valid && m_ready) begin
                if (expected_tallies.size() == 0) begin
                    flag_error("result beat arrived with no expected result waiting");
                end else begin
                    oldest_tally = expected_tallies.pop_front();
                    check_field("slot", 16'(m_data.slot), 16'(oldest_tally.slot));
                    check_field("slot_count", m_data.slot_count, oldest_tally.slot_count);
                    check_field("total_count", m_data.total_count, oldest_tally.total_count);
                    check_field("distinct_count", 16'(m_data.distinct_count),
                                16'(oldest_tally.distinct_count));
                    check_field("status", 16'(m_data.status), 16'(oldest_tally.status));
                end
            end
            if (s_valid && s_ready) begin
                expected_tallies.push_back(tally_key(s_data));
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
                $display("[distinct_key_counting_table] ERROR");
                $finish;
            end
        end
    end

    // Offers one identifier beat and returns at the edge where it is accepted. A random
    // idle gap may come first; with no gap, valid simply stays high into the next beat.
    task automatic offer_id(input logic [dkct_pkg::KEY_W-1:0] id, input logic start);
        dkct_pkg::in_beat_t beat;
        int                 gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        beat.device_id      = id;
        beat.start_of_batch = start;
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_idling(input int sender_pct, input int recv_pct);
        sender_idle_pct = sender_pct;
        recv_stall_pct  = recv_pct;
    endtask

    // The first beat after reset carries no start flag, so it exercises the reset state
    // of the fill count and total. Then the key extremes, a hit, and a start flag on a
    // key that would otherwise have hit.
    task automatic test_first_beats();
        set_idling(0, 0);
        offer_id(16'hFFFF, 1'b0);
        offer_id(16'h0000, 1'b0);
        offer_id(16'hFFFF, 1'b0);
        offer_id(16'h0000, 1'b1);
        offer_id(16'h0000, 1'b0);
        offer_id(16'h5A5A, 1'b1);
    endtask

    // Fills all slots, then drops new keys, hits the first and the last slot (the
    // longest search), and starts a new batch while the table is full.
    task automatic test_table_full();
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            offer_id(dkct_pkg::KEY_W'(i * 16'h0801), i == 0);
        end
        offer_id(16'hFFFF, 1'b0);
        offer_id(16'h0000, 1'b0);
        offer_id(dkct_pkg::KEY_W'((TABLE_SLOTS - 1) * 16'h0801), 1'b0);
        offer_id(16'hFFFF, 1'b0);
        offer_id(16'hFFFF, 1'b1);
    endtask

    // The receiver holds off for a long stretch while beats keep coming, so the output
    // register fills, the next result backs up inside, and the input channel stalls.
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_left <= HOLD_OFF_CYCLES;
        for (int i = 0; i < 12; i++) begin
            offer_id(dkct_pkg::KEY_W'(16'h0100 + (i % 5)), i == 0);
        end
    endtask

    // Mostly well-formed batches: a start flag, then keys drawn from a per-batch pool.
    // Small pools give long runs of hits, pools near the table size give deep searches,
    // and pools above it fill the table and drop beats. Some batches leave out the
    // start flag and carry on from the previous batch, and a few beats are pure noise
    // with a random key and a random start flag.
    task automatic run_random_traffic(input int n_items);
        logic [dkct_pkg::KEY_W-1:0] pool [POOL_MAX];
        int                         pool_size;
        int                         batch_len;
        int                         pick;
        int                         sent;
        bit                         carry_on;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                pool_size = $urandom_range(1, 8);
            end else if (pick < 85) begin
                pool_size = $urandom_range(9, TABLE_SLOTS);
            end else begin
                pool_size = $urandom_range(TABLE_SLOTS + 1, POOL_MAX);
            end
            for (int i = 0; i < pool_size; i++) begin
                pick = $urandom_range(19);
                if (pick == 0) begin
                    pool[i] = '0;
                end else if (pick == 1) begin
                    pool[i] = '1;
                end else begin
                    pool[i] = dkct_pkg::KEY_W'($urandom);
                end
            end
            batch_len = $urandom_range(1, 80);
            carry_on  = ($urandom_range(9) == 0);
            for (int i = 0; i < batch_len && sent < n_items; i++) begin
                if ($urandom_range(19) == 0) begin
                    offer_id(dkct_pkg::KEY_W'($urandom), 1'($urandom));
                end else begin
                    offer_id(pool[$urandom_range(pool_size - 1)], (i == 0) && !carry_on);
                end
                sent++;
            end
        end
    endtask

    // Lowers valid, lets the monitor record the last beat, then waits until every
    // expected result has arrived and a little beyond, so late extras are caught.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_tallies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_first_beats();
        test_table_full();
        test_backpressure();

        // Random traffic through the idling phases: none, a slow sender, a slow
        // receiver, and both idling now and then.
        set_idling(0, 0);
        run_random_traffic(RANDOM_PER_PHASE);
        set_idling(81, 0);
        run_random_traffic(RANDOM_PER_PHASE);
        set_idling(0, 81);
        run_random_traffic(RANDOM_PER_PHASE);
        set_idling(29, 29);
        run_random_traffic(RANDOM_PER_PHASE);

        wait_drained();
        if (expected_tallies.size() != 0) begin
            flag_error("expected results left over at the end");
        end
        if (error_count == 0) begin
            $display("[distinct_key_counting_table] OK");
        end else begin
            $display("[distinct_key_counting_table] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/dkct_pkg.sv
design/dkct_ram.sv
design/distinct_key_counting_table.sv
tb/tb_distinct_key_counting_table.sv
